// ===== hdl/merkle_proof_verify_defines.svh =====
// Assertion helpers for the proof walker.
`ifndef MERKLE_PROOF_VERIFY_DEFINES_SVH
`define MERKLE_PROOF_VERIFY_DEFINES_SVH
`ifndef SYNTHESIS
`define MPV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPV_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPV_ASSERT(label, clk, rst_n, prop, msg)
`define MPV_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/mpv_pkg.sv =====
`default_nettype none
package mpv_pkg;
    localparam int DigestBits = 256;
    localparam int Rounds = 64;

    typedef logic [DigestBits-1:0] digest_t;

    typedef struct packed {
        logic    first;
        logic    sibling_left;
        digest_t digest;
        logic    last;
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BLK0  = 2'd1,
        ST_BLK1  = 2'd2,
        ST_EMIT  = 2'd3
    } hash_state_t;

    typedef logic [31:0] rk_tab_t [0:Rounds-1];
    localparam rk_tab_t RK = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Map one six-bit group to its Base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'd65 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'd71 + {2'b00, v};
        else if (v < 6'd62)
            c = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            c = 8'd43;
        else
            c = 8'd47;
        return c;
    endfunction

    // Base64 text of a 256-bit digest: 44 characters, trailing pad
    function automatic logic [351:0] b64_text(input digest_t d);
        logic [263:0] padded;
        logic [351:0] t;
        padded = {d, 8'h00};
        for (int i = 0; i < 43; i++)
            t[351-8*i -: 8] = b64_char(padded[263-6*i -: 6]);
        t[7:0] = 8'd61;
        return t;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ===== hdl/mpv_if.sv =====
`default_nettype none
interface mpv_if #(parameter int Width = 8);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/mpv_front.sv =====
`default_nettype none
// Two-entry request queue between the input channel and the hash engine
module mpv_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mpv_pkg::req_t in_req,
    output logic               q_valid,
    input  wire logic          q_ready,
    output mpv_pkg::req_t      q_req
);
    import mpv_pkg::*;

    req_t       ent_reg [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = ent_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store accepted requests
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= in_req;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/mpv_back.sv =====
`default_nettype none
`include "merkle_proof_verify_defines.svh"
// Hash engine: one SHA-256 round per cycle over two blocks per sibling, then root output at the end of a walk
module mpv_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire mpv_pkg::req_t q_req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mpv_pkg::digest_t   root
);
    import mpv_pkg::*;

    hash_state_t state_reg, state_next;
    digest_t     run_reg;
    logic [511:0] w_reg;
    logic [511:0] blk1_reg;
    logic [255:0] v_reg, h_reg;
    logic [5:0]  rnd_reg;
    logic        emit_reg;
    logic        out_valid_reg;
    digest_t     root_reg;

    logic [703:0] msg;
    logic [351:0] t_run, t_sib;
    logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, w0, wnew, s0, s1;
    logic [255:0] v_new, h_sum;
    logic         take, out_free, root_load;

    // Only a leaf that is also the root needs the output register at once
    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = (state_reg == ST_IDLE) && (out_free || !(q_req.first && q_req.last));
    assign take      = q_valid && q_ready;
    assign root_load = (take && q_req.first && q_req.last) || ((state_reg == ST_EMIT) && out_free);
    assign out_valid = out_valid_reg;
    assign root      = root_reg;

    // Build the 88-byte message
    always_comb
    begin
        t_run = b64_text(run_reg);
        t_sib = b64_text(q_req.digest);
        msg   = q_req.sibling_left ? {t_sib, t_run} : {t_run, t_sib};
    end

    // One compression round and schedule step
    always_comb
    begin
        {a, b, c, d, e, f, g, hh} = v_reg;
        w0   = w_reg[511:480];
        s0   = ror32(w_reg[479:448], 7) ^ ror32(w_reg[479:448], 18) ^ (w_reg[479:448] >> 3);
        s1   = ror32(w_reg[63:32], 17) ^ ror32(w_reg[63:32], 19) ^ (w_reg[63:32] >> 10);
        wnew = w0 + s0 + w_reg[223:192] + s1;
        t1   = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
             + RK[rnd_reg] + w0;
        t2   = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        v_new = {t1 + t2, a, b, c, d + t1, e, f, g};
        for (int i = 0; i < 8; i++)
            h_sum[255-32*i -: 32] = h_reg[255-32*i -: 32] + v_new[255-32*i -: 32];
    end

    // Sequence the two blocks
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (take && !q_req.first)
                    state_next = ST_BLK0;
            ST_BLK0:
                if (rnd_reg == 6'd63)
                    state_next = ST_BLK1;
            ST_BLK1:
                if (rnd_reg == 6'd63)
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            rnd_reg       <= '0;
            root_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (take)
                    begin
                        rnd_reg <= '0;
                        if (q_req.first)
                        begin
                            run_reg <= q_req.digest;
                            if (q_req.last)
                                root_reg <= q_req.digest;
                        end
                    end
                ST_BLK0, ST_BLK1:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if ((state_reg == ST_BLK1) && (rnd_reg == 6'd63))
                        run_reg <= h_sum;
                end
                ST_EMIT:
                    if (out_free)
                        root_reg <= run_reg;
                default:
                    rnd_reg <= '0;
            endcase
            // Raise the root valid on a load, drop it once taken
            if (root_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    emit_reg <= q_req.last;
                    w_reg    <= msg[703:192];
                    blk1_reg <= {msg[191:0], 8'h80, 301'd0, 11'd704};
                    v_reg    <= IV;
                    h_reg    <= IV;
                end
            ST_BLK0:
            begin
                if (rnd_reg == 6'd63)
                begin
                    v_reg <= h_sum;
                    h_reg <= h_sum;
                    w_reg <= blk1_reg;
                end
                else
                begin
                    w_reg <= {w_reg[479:0], wnew};
                    v_reg <= v_new;
                end
            end
            ST_BLK1:
            begin
                w_reg <= {w_reg[479:0], wnew};
                v_reg <= v_new;
            end
            default:
                v_reg <= v_reg;
        endcase
    end

    `MPV_ASSERT(a_no_take_busy, clk, rst_n, (state_reg != ST_IDLE) |-> !q_ready,
        "request taken while hashing")
    `MPV_ASSERT(a_blk_order, clk, rst_n,
        (state_reg == ST_BLK0 && rnd_reg == 6'd63) |=> (state_reg == ST_BLK1),
        "second block skipped")
    `MPV_ASSERT(a_emit_out, clk, rst_n,
        (state_reg == ST_EMIT && out_free) |=> out_valid_reg, "root lost")
endmodule
`default_nettype wire

// ===== hdl/merkle_proof_verify.sv =====
// Merkle proof walker, SHA-256 over Base64 text of the digests.
// Channels: in (valid/ready, payload first, sibling_left, digest_w0..w3,
// last) and out (valid/ready, payload root_w0..w3). A request is taken on
// a rising edge with valid and ready high.
// A leaf request (first) only loads the running digest in the hash
// engine; it is not hashed. A sibling request is loaded, then run
// through the single compression round unit over two 64-round blocks.
// A sibling request marked last then passes through the emit state,
// which loads the root into the output register once it is free.
// A two-entry queue in front of the engine accepts requests while the
// engine works; the engine takes no new request until it has finished
// the current one.
// Reset clears the running digest to zero and empties queue and output.
// While the receiver stalls the root stays in its register; the engine
// still hashes sibling requests and then waits to emit the next root.
// A leaf request that is also the root waits until the register is free.
`default_nettype none
module merkle_proof_verify (
    input wire logic clk,
    input wire logic rst_n,
    mpv_if.sink      in,
    mpv_if.source    out
);
    import mpv_pkg::*;

    req_t    in_req, q_req;
    logic    q_valid, q_ready;
    digest_t root;

    assign in_req = req_t'(in.data);
    assign out.data = root;

    mpv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    mpv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .root      (root)
    );
endmodule
`default_nettype wire

// ===== sim/merkle_proof_verify_test.sv =====
`default_nettype none
module merkle_proof_verify_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mpv_pkg::*;

    localparam int StallLimit = 5000;
    localparam int DrainCycles = 300;

    logic clk;
    logic rst_n;

    mpv_if #(.Width($bits(req_t))) req_ch ();
    mpv_if #(.Width(DigestBits)) root_ch ();

    merkle_proof_verify uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_ch.sink),
        .out   (root_ch.source)
    );

    // Predictor state and the roots still awaited
    digest_t walk_digest;
    digest_t root_queue[$];
    int      mismatches;
    int      stray_roots;
    int      hold_off_cycles;
    bit      sink_idle_on;
    bit      source_idle_on;
    int      quiet_cycles;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One SHA-256 compression on a 512-bit block
    function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] blk);
        logic [31:0] w [0:63];
        logic [31:0] v [0:7];
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [255:0] r;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511-32*i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = h[255-32*i -: 32];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            r[255-32*i -: 32] = h[255-32*i -: 32] + v[i];
        return r;
    endfunction

    // Base64 alphabet lookup
    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        if (s <= 6'd25)
            c = "A" + s;
        else if (s <= 6'd51)
            c = "a" + (s - 6'd26);
        else if (s <= 6'd61)
            c = "0" + (s - 6'd52);
        else if (s == 6'd62)
            c = "+";
        else
            c = "/";
        return c;
    endfunction

    // 44-character text of one digest, one pad character
    function automatic logic [351:0] digest_text(input digest_t d);
        logic [263:0] bits;
        logic [351:0] txt;
        bits = {d, 8'h00};
        for (int i = 0; i < 43; i++)
            txt[351-8*i -: 8] = sextet_char(bits[263-6*i -: 6]);
        txt[7:0] = "=";
        return txt;
    endfunction

    // Hash of the joined sibling and running texts (88 bytes, two blocks)
    function automatic digest_t pair_hash(input digest_t running, input digest_t sibling,
                                          input logic sib_left);
        logic [703:0]  msg;
        logic [1023:0] padded;
        logic [255:0]  h;
        if (sib_left)
            msg = {digest_text(sibling), digest_text(running)};
        else
            msg = {digest_text(running), digest_text(sibling)};
        padded = {msg, 8'h80, 248'd0, 64'd704};
        h = IV;
        h = sha_compress(h, padded[1023:512]);
        h = sha_compress(h, padded[511:0]);
        return h;
    endfunction

    // Advance the walk by one request and queue the root if one is due
    function automatic void walk_step(input req_t r);
        if (r.first)
            walk_digest = r.digest;
        else
            walk_digest = pair_hash(walk_digest, r.digest, r.sibling_left);
        if (r.last)
            root_queue = {root_queue, walk_digest};
    endfunction

    function automatic digest_t rand_digest();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offer one request, after an optional random gap, and hold it until taken
    task automatic send_request(input logic first, input logic sib_left, input digest_t d,
                                input logic last);
        req_t r;
        int   gap;
        r.first = first;
        r.sibling_left = sib_left;
        r.digest = d;
        r.last = last;
        gap = source_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        walk_step(r);
    endtask

    task automatic source_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_roots();
        source_idle();
        while (root_queue.size() != 0)
            @(posedge clk);
    endtask

    // Sink: random ready, with an occasional long hold-off
    initial
    begin
        int gap;
        root_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                gap = sink_idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0)
            begin
                root_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            root_ch.ready <= 1'b1;
            @(posedge clk);
            while (!root_ch.valid)
                @(posedge clk);
        end
    end

    // Check each root against the oldest awaited one; count a root with none awaited as stray
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && root_ch.valid && root_ch.ready)
        begin
            if (root_queue.size() == 0)
            begin
                stray_roots++;
                if (mismatches + stray_roots <= 10)
                    $display("unexpected root %h", root_ch.data);
            end
            else
            begin
                want = root_queue.pop_front();
                for (int i = 0; i < 4; i++)
                    if (root_ch.data[255-64*i -: 64] !== want[255-64*i -: 64])
                    begin
                        mismatches++;
                        if (mismatches + stray_roots <= 10)
                            $display("root_w%0d: expected %h, actual %h", i,
                                     want[255-64*i -: 64], root_ch.data[255-64*i -: 64]);
                    end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (root_ch.valid && root_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= StallLimit)
        begin
            $display("merkle_proof_verify_test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_no_leaf();
        send_request(1'b0, 1'b0, '0, 1'b1);
        send_request(1'b0, 1'b1, '1, 1'b1);
    endtask

    task automatic test_leaf_extremes();
        send_request(1'b1, 1'b0, '0, 1'b1);
        send_request(1'b1, 1'b1, '1, 1'b1);
        send_request(1'b1, 1'b0, {4{64'h8000_0000_0000_0001}}, 1'b1);
    endtask

    task automatic test_both_sides();
        send_request(1'b1, 1'b0, rand_digest(), 1'b0);
        send_request(1'b0, 1'b1, '1, 1'b0);
        send_request(1'b0, 1'b0, '0, 1'b1);
        send_request(1'b0, 1'b0, rand_digest(), 1'b0);
        send_request(1'b0, 1'b1, rand_digest(), 1'b1);
    endtask

    task automatic test_repeated_first();
        send_request(1'b1, 1'b0, rand_digest(), 1'b0);
        send_request(1'b1, 1'b1, rand_digest(), 1'b0);
        send_request(1'b0, 1'b1, rand_digest(), 1'b1);
    endtask

    // Stall the receiver long enough for the input to back up
    task automatic test_back_pressure();
        hold_off_cycles = 900;
        for (int i = 0; i < 8; i++)
            send_request(i == 0, 1'($urandom_range(0, 1)), rand_digest(), 1'(i % 2));
        wait_for_roots();
    endtask

    // Well-formed walks mostly, with stray requests mixed in
    task automatic test_random_walks(input int budget);
        int sent;
        int depth;
        sent = 0;
        while (sent < budget)
        begin
            if ((sent / 100) % 3 == 2)
            begin
                sink_idle_on = 1'b0;
                source_idle_on = 1'b0;
            end
            else
            begin
                sink_idle_on = 1'b1;
                source_idle_on = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_digest(),
                             1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                depth = $urandom_range(0, 5);
                send_request(1'b1, 1'($urandom_range(0, 1)), rand_digest(), depth == 0);
                for (int i = 1; i <= depth; i++)
                    send_request(1'b0, 1'($urandom_range(0, 1)), rand_digest(), i == depth);
                sent += depth + 1;
            end
            if ($urandom_range(0, 60) == 0)
                wait_for_roots();
        end
        wait_for_roots();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        walk_digest = '0;
        mismatches = 0;
        stray_roots = 0;
        hold_off_cycles = 0;
        sink_idle_on = 1'b1;
        source_idle_on = 1'b1;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_leaf();
        test_leaf_extremes();
        test_both_sides();
        test_repeated_first();
        wait_for_roots();
        test_back_pressure();
        test_random_walks(1130);

        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && stray_roots == 0 && root_queue.size() == 0)
            $display("merkle_proof_verify_test passed");
        else
            $display("merkle_proof_verify_test failed");
        $finish;
    end
endmodule
`default_nettype wire
